// ===== hdl/sles_pkg.sv =====
// ----------------------------------------------------------------------------
// sles_pkg: shared definitions for the save layer elision stack
// Holds the stack sizes, the command codes and the memory request record
// that passes from the stack controller to the top level.
// ----------------------------------------------------------------------------
package sles_pkg;

  // Stack sizing.
  localparam int STACK_DEPTH = 64;
  localparam int INDEX_BITS  = 16;
  localparam int ADDR_BITS   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_BITS  = $clog2(STACK_DEPTH + 1);

  // Field widths of the channels.
  localparam int OP_BITS        = 3;
  localparam int REC_IDX_BITS   = 16;
  localparam int LAYER_IDX_BITS = 16;

  // Stored index width: the kept index bits that can reach the output.
  localparam int IDX_W = (INDEX_BITS < REC_IDX_BITS) ? INDEX_BITS : REC_IDX_BITS;

  // Count of save levels above the stored stack.
  localparam int EXCESS_BITS = 16;
  localparam logic [EXCESS_BITS-1:0] EXCESS_MAX = '1;

  // Command codes.
  typedef enum logic [OP_BITS-1:0] {
    OP_OTHER      = 3'd0,
    OP_LAYER_SAVE = 3'd1,
    OP_SAVE       = 3'd2,
    OP_DRAW       = 3'd3,
    OP_RESTORE    = 3'd4
  } op_kind_t;

  // Memory requests issued for one accepted command.
  typedef struct packed {
    logic                 wr_flag_en;
    logic                 wr_idx_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic                 wr_flag;
    logic [IDX_W-1:0]     wr_index;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
  } mem_req_t;

endpackage

// ===== hdl/save_layer_elision_stack.sv =====
// ----------------------------------------------------------------------------
// save_layer_elision_stack: finds layer saves that can become plain saves
// Top level: command channel, stack memories and the result register.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one drawing command per transfer. Save and
//   layer save commands push a level, single draws may clear the top
//   level's match flag, and restores pop a level. When a popped level
//   still matches, its recorded index leaves on the out_ channel.
//   Throughput is one command per cycle while in_stall is low. A restore's
//   result passes through the stack memory read register and then the
//   result register before it appears on out_valid.
//   The stack lives in two synchronous RAMs (match flags and indices);
//   pushes and draw updates write in the transfer cycle, restores read the
//   top entry, so consecutive commands never collide on an entry.
//   Reset clears the stack depth, the overflow count and the valid flags;
//   the memories are not cleared, and no entry is read before it is written.
//   When out_stall holds a result, a pending top read waits in the read
//   stage and in_stall rises until the result register frees up.
// ----------------------------------------------------------------------------
module save_layer_elision_stack (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sles_pkg::OP_BITS-1:0]         in_op_kind,
  input  logic [sles_pkg::REC_IDX_BITS-1:0]    in_record_index,
  input  logic                                 in_paint_present,
  input  logic                                 in_paint_has_effect,
  input  logic                                 in_paint_opaque,
  input  logic                                 in_paint_src_over,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sles_pkg::LAYER_IDX_BITS-1:0]  out_layer_index
);

  sles_pkg::mem_req_t                  mem_req;
  logic                                in_accept;
  logic                                rd_flag;
  logic [sles_pkg::IDX_W-1:0]          rd_index;
  logic                                rd_valid_r, rd_valid_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [sles_pkg::LAYER_IDX_BITS-1:0] out_index_r;
  logic                                read_blocked;
  logic                                load_out;

  // The read stage holds only when it has data and the result register is stuck.
  assign read_blocked = rd_valid_r && out_valid_r && out_stall;
  assign in_stall     = read_blocked;
  assign in_accept    = in_valid && !in_stall;

  sles_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (in_accept),
    .op_kind          (in_op_kind),
    .record_index     (in_record_index),
    .paint_present    (in_paint_present),
    .paint_has_effect (in_paint_has_effect),
    .paint_opaque     (in_paint_opaque),
    .paint_src_over   (in_paint_src_over),
    .mem_req          (mem_req)
  );

  // Match flag memory.
  sles_ram #(
    .WIDTH (1),
    .DEPTH (sles_pkg::STACK_DEPTH),
    .AW    (sles_pkg::ADDR_BITS)
  ) u_flag_ram (
    .clk   (clk),
    .we    (mem_req.wr_flag_en),
    .waddr (mem_req.wr_addr),
    .wdata (mem_req.wr_flag),
    .re    (mem_req.rd_en),
    .raddr (mem_req.rd_addr),
    .rdata (rd_flag)
  );

  // Save index memory.
  sles_ram #(
    .WIDTH (sles_pkg::IDX_W),
    .DEPTH (sles_pkg::STACK_DEPTH),
    .AW    (sles_pkg::ADDR_BITS)
  ) u_index_ram (
    .clk   (clk),
    .we    (mem_req.wr_idx_en),
    .waddr (mem_req.wr_addr),
    .wdata (mem_req.wr_index),
    .re    (mem_req.rd_en),
    .raddr (mem_req.rd_addr),
    .rdata (rd_index)
  );

  // Read stage and result register control.
  assign load_out = rd_valid_r && !read_blocked && rd_flag;

  always_comb begin
    rd_valid_nxt  = read_blocked ? rd_valid_r : mem_req.rd_en;
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_index_r <= sles_pkg::LAYER_IDX_BITS'(rd_index);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_layer_index = out_index_r;

endmodule

// ===== hdl/sles_ram.sv =====
// ----------------------------------------------------------------------------
// sles_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; the read data holds while
// no read is enabled.
// ----------------------------------------------------------------------------
module sles_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sles_ctrl.sv =====
// ----------------------------------------------------------------------------
// sles_ctrl: stack pointer and overflow count control
// Decodes each accepted command, updates the stack depth and the count of
// levels above the stack, and issues the memory writes and the top read.
// ----------------------------------------------------------------------------
module sles_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [sles_pkg::OP_BITS-1:0]         op_kind,
  input  logic [sles_pkg::REC_IDX_BITS-1:0]    record_index,
  input  logic                                 paint_present,
  input  logic                                 paint_has_effect,
  input  logic                                 paint_opaque,
  input  logic                                 paint_src_over,
  output sles_pkg::mem_req_t                   mem_req
);

  logic [sles_pkg::DEPTH_BITS-1:0]  depth_r, depth_nxt;
  logic [sles_pkg::EXCESS_BITS-1:0] excess_r, excess_nxt;
  logic [sles_pkg::DEPTH_BITS-1:0]  top_pos;
  logic                             stack_full;
  logic                             save_plain;
  logic                             draw_plain;

  // Paint classification: absent paint always counts as plain.
  assign save_plain = !paint_present ||
                      (!paint_has_effect && paint_opaque && paint_src_over);
  assign draw_plain = !paint_present || (!paint_has_effect && paint_src_over);

  assign top_pos    = depth_r - sles_pkg::DEPTH_BITS'(1);
  assign stack_full = (depth_r >= sles_pkg::DEPTH_BITS'(sles_pkg::STACK_DEPTH));

  // Command decode and memory requests.
  always_comb begin
    depth_nxt          = depth_r;
    excess_nxt         = excess_r;
    mem_req.wr_flag_en = 1'b0;
    mem_req.wr_idx_en  = 1'b0;
    mem_req.wr_addr    = depth_r[sles_pkg::ADDR_BITS-1:0];
    mem_req.wr_flag    = 1'b0;
    mem_req.wr_index   = record_index[sles_pkg::IDX_W-1:0];
    mem_req.rd_en      = 1'b0;
    mem_req.rd_addr    = top_pos[sles_pkg::ADDR_BITS-1:0];
    if (accept) begin
      case (op_kind)
        sles_pkg::OP_LAYER_SAVE, sles_pkg::OP_SAVE: begin
          if (excess_r == '0 && !stack_full) begin
            mem_req.wr_flag_en = 1'b1;
            mem_req.wr_idx_en  = 1'b1;
            mem_req.wr_flag    = (op_kind == sles_pkg::OP_LAYER_SAVE) && save_plain;
            depth_nxt          = depth_r + sles_pkg::DEPTH_BITS'(1);
          end else if (excess_r != sles_pkg::EXCESS_MAX) begin
            excess_nxt = excess_r + sles_pkg::EXCESS_BITS'(1);
          end
        end
        sles_pkg::OP_DRAW: begin
          // Clearing an already clear flag is harmless, so no read is needed.
          if (excess_r == '0 && depth_r != '0 && !draw_plain) begin
            mem_req.wr_flag_en = 1'b1;
            mem_req.wr_addr    = top_pos[sles_pkg::ADDR_BITS-1:0];
          end
        end
        sles_pkg::OP_RESTORE: begin
          if (excess_r != '0) begin
            excess_nxt = excess_r - sles_pkg::EXCESS_BITS'(1);
          end else if (depth_r != '0) begin
            depth_nxt     = top_pos;
            mem_req.rd_en = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Stack pointer and overflow count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= '0;
      excess_r <= '0;
    end else begin
      depth_r  <= depth_nxt;
      excess_r <= excess_nxt;
    end
  end

  // The stack pointer never passes the stack size.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= sles_pkg::DEPTH_BITS'(sles_pkg::STACK_DEPTH))
    else $error("stack depth beyond stack size");

  // Levels are only counted once the stored stack is full.
  a_excess_full: assert property (@(posedge clk) disable iff (!rst_n)
    excess_r != '0 |-> stack_full)
    else $error("overflow count while stack not full");

  // A command never both reads and writes the stack.
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.rd_en |-> !(mem_req.wr_flag_en || mem_req.wr_idx_en))
    else $error("read and write issued together");

  // A top read always pops exactly one stored level.
  a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.rd_en |=> depth_r == $past(top_pos))
    else $error("pop did not lower the depth by one");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the save layer elision stack
// Streams drawing commands into the block with random gaps and output
// stalls, predicts which layer saves come back as plain-save candidates,
// and compares every result transfer against the predicted index.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Bench timing and run shape.
  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 11;
  localparam int N_RANDOM     = 1650;
  localparam int TAIL_ITEMS   = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int WD_LIMIT     = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 10;

  // Paint bit groups, ordered {present, effect, opaque, src_over}.
  localparam logic [3:0] PAINT_PLAIN       = 4'b1011;
  localparam logic [3:0] PAINT_EFFECT      = 4'b1111;
  localparam logic [3:0] PAINT_TRANSLUCENT = 4'b1001;
  localparam logic [3:0] PAINT_BLEND       = 4'b1010;

  localparam logic [sles_pkg::REC_IDX_BITS-1:0] IDX_MASK =
    (sles_pkg::INDEX_BITS >= sles_pkg::REC_IDX_BITS) ?
      {sles_pkg::REC_IDX_BITS{1'b1}} :
      sles_pkg::REC_IDX_BITS'((64'd1 << sles_pkg::INDEX_BITS) - 1);

  typedef struct packed {
    logic [sles_pkg::OP_BITS-1:0]      op;
    logic [sles_pkg::REC_IDX_BITS-1:0] idx;
    logic                              present;
    logic                              effect;
    logic                              opaque;
    logic                              src_over;
  } cmd_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                                in_valid            = 1'b0;
  logic                                in_stall;
  logic [sles_pkg::OP_BITS-1:0]        in_op_kind          = '0;
  logic [sles_pkg::REC_IDX_BITS-1:0]   in_record_index     = '0;
  logic                                in_paint_present    = 1'b0;
  logic                                in_paint_has_effect = 1'b0;
  logic                                in_paint_opaque     = 1'b0;
  logic                                in_paint_src_over   = 1'b0;
  logic                                out_valid;
  logic                                out_stall           = 1'b0;
  logic [sles_pkg::LAYER_IDX_BITS-1:0] out_layer_index;

  save_layer_elision_stack i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op_kind          (in_op_kind),
    .in_record_index     (in_record_index),
    .in_paint_present    (in_paint_present),
    .in_paint_has_effect (in_paint_has_effect),
    .in_paint_opaque     (in_paint_opaque),
    .in_paint_src_over   (in_paint_src_over),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_layer_index     (out_layer_index)
  );

  // Commands waiting to be driven, and layer indices predicted to come out.
  cmd_t                                cmd_q[$];
  logic [sles_pkg::LAYER_IDX_BITS-1:0] elided_idx_q[$];

  // Shadow of the block's stack.
  logic                              stk_match [sles_pkg::STACK_DEPTH];
  logic [sles_pkg::REC_IDX_BITS-1:0] stk_index [sles_pkg::STACK_DEPTH];
  int                                stk_lvl  = 0;
  int                                over_lvl = 0;

  // Bookkeeping.
  int   n_err       = 0;
  int   n_results   = 0;
  int   in_done_cnt = 0;
  int   issued_cnt  = 0;
  int   total_cmds  = 0;
  int   holdoff_at  = 0;
  int   cyc_cnt     = 0;
  int   quiet_cyc   = 0;
  int   blocked_cyc = 0;
  int   peak_lvl    = 0;
  int   peak_over   = 0;
  int   gap_left    = 0;
  int   stall_left  = 0;
  int   hold_left   = 0;
  logic hold_done   = 1'b0;

  // Clock.
  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // Reset is held low from the start, then released once on a falling edge.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  task automatic note_failure(input string msg);
    n_err++;
    if (n_err <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  // Open a save level, or count it above the stored stack.
  task automatic push_level(input logic hit,
                            input logic [sles_pkg::REC_IDX_BITS-1:0] kept);
    if (over_lvl == 0 && stk_lvl < sles_pkg::STACK_DEPTH) begin
      stk_match[stk_lvl] = hit;
      stk_index[stk_lvl] = kept;
      stk_lvl++;
      if (stk_lvl > peak_lvl) peak_lvl = stk_lvl;
    end else if (over_lvl < int'(sles_pkg::EXCESS_MAX)) begin
      over_lvl++;
      if (over_lvl > peak_over) peak_over = over_lvl;
    end
  endtask

  // Apply one accepted command to the shadow stack and queue any result.
  task automatic predict_elision(input cmd_t c);
    logic [sles_pkg::REC_IDX_BITS-1:0] kept;
    logic                              plain_save;
    logic                              plain_draw;
    kept       = c.idx & IDX_MASK;
    plain_save = !c.present || (!c.effect && c.opaque && c.src_over);
    plain_draw = !c.present || (!c.effect && c.src_over);
    case (c.op)
      sles_pkg::OP_LAYER_SAVE: push_level(plain_save, kept);
      sles_pkg::OP_SAVE:       push_level(1'b0, kept);
      sles_pkg::OP_DRAW: begin
        if (over_lvl == 0 && stk_lvl > 0 && stk_match[stk_lvl-1] && !plain_draw)
          stk_match[stk_lvl-1] = 1'b0;
      end
      sles_pkg::OP_RESTORE: begin
        if (over_lvl > 0) begin
          over_lvl--;
        end else if (stk_lvl > 0) begin
          stk_lvl--;
          if (stk_match[stk_lvl])
            elided_idx_q.insert(elided_idx_q.size(),
                                sles_pkg::LAYER_IDX_BITS'(stk_index[stk_lvl]));
        end
      end
      default: ;
    endcase
  endtask

  // Random idling is off in quiet windows and over the tail of the run.
  function automatic logic idle_allowed();
    return ((cyc_cnt / 512) % 4 != 3) && (in_done_cnt < total_cmds - TAIL_ITEMS);
  endfunction

  // Input sampling, result checking and the watchdog.
  always @(posedge clk) begin
    cmd_t c;
    if (rst_n) begin
      cyc_cnt++;
      quiet_cyc++;
      if (in_valid && in_stall) blocked_cyc++;
      if (in_valid && !in_stall) begin
        c.op       = in_op_kind;
        c.idx      = in_record_index;
        c.present  = in_paint_present;
        c.effect   = in_paint_has_effect;
        c.opaque   = in_paint_opaque;
        c.src_over = in_paint_src_over;
        predict_elision(c);
        in_done_cnt++;
        quiet_cyc = 0;
      end
      if (out_valid && !out_stall) begin
        n_results++;
        quiet_cyc = 0;
        if (elided_idx_q.size() == 0) begin
          note_failure($sformatf("unexpected result, layer_index got %h", out_layer_index));
        end else begin
          logic [sles_pkg::LAYER_IDX_BITS-1:0] want;
          want = elided_idx_q.pop_front();
          if (want !== out_layer_index)
            note_failure($sformatf("layer_index expected %h got %h", want, out_layer_index));
        end
      end
      if (quiet_cyc >= WD_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", WD_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Command driver: holds each command until its transfer, then may pause.
  always @(negedge clk) begin
    logic nv;
    cmd_t c;
    if (rst_n) begin
      nv = in_valid;
      if (in_valid && in_done_cnt == issued_cnt) begin
        nv = 1'b0;
        if (idle_allowed() && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 19);
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() > 0) begin
          c = cmd_q.pop_front();
          in_op_kind          <= c.op;
          in_record_index     <= c.idx;
          in_paint_present    <= c.present;
          in_paint_has_effect <= c.effect;
          in_paint_opaque     <= c.opaque;
          in_paint_src_over   <= c.src_over;
          nv = 1'b1;
          issued_cnt++;
        end
      end
      in_valid <= nv;
    end
  end

  // Result receiver: random stall bursts plus one long hold-off.
  always @(negedge clk) begin
    logic st;
    if (hold_left > 0) begin
      hold_left--;
      st = 1'b1;
    end else if (rst_n && !hold_done && in_done_cnt >= holdoff_at) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      st = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      st = 1'b1;
    end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      st = 1'b1;
    end else begin
      st = 1'b0;
    end
    out_stall <= st;
  end

  task automatic add_cmd(input logic [sles_pkg::OP_BITS-1:0] op,
                         input logic [sles_pkg::REC_IDX_BITS-1:0] idx,
                         input logic [3:0] paint);
    cmd_t c;
    c.op = op;
    c.idx = idx;
    {c.present, c.effect, c.opaque, c.src_over} = paint;
    cmd_q.insert(cmd_q.size(), c);
  endtask

  function automatic logic [sles_pkg::REC_IDX_BITS-1:0] rnd_idx();
    return sles_pkg::REC_IDX_BITS'($urandom);
  endfunction

  // Plain layer-save paint: either absent with junk bits, or fully plain.
  function automatic logic [3:0] plain_paint();
    return ($urandom_range(0, 1) == 0) ? {1'b0, 3'($urandom)} : PAINT_PLAIN;
  endfunction

  // Stimulus build and end of run.
  initial begin
    int counted;
    int gen_lvl;
    int cap;
    int seg;
    int r;
    int p_push;

    // Unused op codes and commands on an empty stack change nothing.
    add_cmd(sles_pkg::OP_OTHER, 16'hFFFF, 4'hF);
    for (int k = 1; k <= 3; k++)
      add_cmd(sles_pkg::OP_BITS'(sles_pkg::OP_RESTORE + k), rnd_idx(), 4'($urandom));
    add_cmd(sles_pkg::OP_RESTORE, 16'hFFFF, PAINT_EFFECT);
    add_cmd(sles_pkg::OP_DRAW, 16'h0000, PAINT_EFFECT);

    // Absent paint matches whatever the other bits say.
    add_cmd(sles_pkg::OP_LAYER_SAVE, 16'hFFFF, 4'b0100);
    add_cmd(sles_pkg::OP_RESTORE, rnd_idx(), 4'h0);

    // A translucent draw or an absent-paint draw leaves the match alone.
    add_cmd(sles_pkg::OP_LAYER_SAVE, 16'h0000, PAINT_PLAIN);
    add_cmd(sles_pkg::OP_DRAW, rnd_idx(), PAINT_TRANSLUCENT);
    add_cmd(sles_pkg::OP_DRAW, rnd_idx(), 4'b0110);
    add_cmd(sles_pkg::OP_RESTORE, rnd_idx(), 4'h0);

    // A draw with effects kills the match.
    add_cmd(sles_pkg::OP_LAYER_SAVE, 16'h5A5A, PAINT_PLAIN);
    add_cmd(sles_pkg::OP_DRAW, rnd_idx(), PAINT_EFFECT);
    add_cmd(sles_pkg::OP_RESTORE, rnd_idx(), 4'h0);

    // Non-plain layer saves and plain saves never match; a blend draw clears.
    add_cmd(sles_pkg::OP_LAYER_SAVE, 16'hA5A5, PAINT_TRANSLUCENT);
    add_cmd(sles_pkg::OP_RESTORE, rnd_idx(), 4'h0);
    add_cmd(sles_pkg::OP_LAYER_SAVE, rnd_idx(), PAINT_BLEND);
    add_cmd(sles_pkg::OP_LAYER_SAVE, rnd_idx(), PAINT_EFFECT);
    add_cmd(sles_pkg::OP_SAVE, rnd_idx(), PAINT_PLAIN);
    add_cmd(sles_pkg::OP_LAYER_SAVE, 16'h1234, PAINT_PLAIN);
    add_cmd(sles_pkg::OP_DRAW, rnd_idx(), PAINT_BLEND);
    repeat (4) add_cmd(sles_pkg::OP_RESTORE, rnd_idx(), 4'h0);

    // Full stack with a few levels above it: the draw up there is ignored.
    repeat (sles_pkg::STACK_DEPTH) add_cmd(sles_pkg::OP_LAYER_SAVE, rnd_idx(), plain_paint());
    repeat (3) add_cmd(sles_pkg::OP_SAVE, rnd_idx(), 4'($urandom));
    add_cmd(sles_pkg::OP_DRAW, rnd_idx(), PAINT_EFFECT);
    repeat (3) add_cmd(sles_pkg::OP_RESTORE, rnd_idx(), 4'($urandom));
    add_cmd(sles_pkg::OP_DRAW, rnd_idx(), 4'b0101);
    repeat (sles_pkg::STACK_DEPTH) add_cmd(sles_pkg::OP_RESTORE, rnd_idx(), 4'($urandom));

    // Random nested save/draw/restore traffic with some noise mixed in.
    holdoff_at = cmd_q.size() + 200;
    counted = 0;
    gen_lvl = 0;
    cap = 8;
    seg = 0;
    while (counted < N_RANDOM) begin
      if (seg == 0) begin
        case ($urandom_range(0, 3))
          0:       cap = 2;
          1:       cap = 8;
          2:       cap = 20;
          default: cap = sles_pkg::STACK_DEPTH + 6;
        endcase
        seg = (cap > sles_pkg::STACK_DEPTH) ? 200 : $urandom_range(20, 80);
      end
      seg--;
      r = $urandom_range(0, 99);
      if (gen_lvl == 0) p_push = 70;
      else if (gen_lvl >= cap) p_push = 15;
      else if (cap > sles_pkg::STACK_DEPTH) p_push = 60;
      else p_push = 40;
      if (r < 6) begin
        if ($urandom_range(0, 3) == 0) begin
          add_cmd(sles_pkg::OP_OTHER, rnd_idx(), 4'($urandom));
        end else begin
          add_cmd(sles_pkg::OP_BITS'(sles_pkg::OP_RESTORE + $urandom_range(1, 3)),
                  rnd_idx(), 4'($urandom));
        end
      end else if (r < 6 + p_push) begin
        if ($urandom_range(0, 3) == 0)
          add_cmd(sles_pkg::OP_SAVE, rnd_idx(), 4'($urandom));
        else if ($urandom_range(0, 9) < 6)
          add_cmd(sles_pkg::OP_LAYER_SAVE, rnd_idx(), plain_paint());
        else
          add_cmd(sles_pkg::OP_LAYER_SAVE, rnd_idx(), 4'($urandom));
        gen_lvl++;
        counted++;
      end else if (r < 26 + p_push) begin
        add_cmd(sles_pkg::OP_DRAW, rnd_idx(), 4'($urandom));
        if (gen_lvl > 0) counted++;
      end else begin
        add_cmd(sles_pkg::OP_RESTORE, rnd_idx(), 4'($urandom));
        if (gen_lvl > 0) begin
          gen_lvl--;
          counted++;
        end
      end
    end
    while (gen_lvl > 0) begin
      add_cmd(sles_pkg::OP_RESTORE, rnd_idx(), 4'($urandom));
      gen_lvl--;
    end
    total_cmds = cmd_q.size();

    // Wait for every command to go in and every result to come out.
    @(posedge rst_n);
    while (cmd_q.size() != 0 || in_valid) @(posedge clk);
    while (elided_idx_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (elided_idx_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", elided_idx_q.size()));

    $display("Ran %0d commands, checked %0d elided layer indices, %0d errors.",
             in_done_cnt, n_results, n_err);
    $display("Stack peak %0d of %0d, up to %0d levels above it, input held %0d cycles.",
             peak_lvl, sles_pkg::STACK_DEPTH, peak_over, blocked_cyc);
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
